### rtl/rgp_pkg.sv
// ----------------------------------------------------------------------------
// rgp_pkg
// Shared constants and types for the rectangle grid placer: grid geometry,
// label limits, result codes and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package rgp_pkg;

  localparam int GRID_ROWS  = 16;
  localparam int GRID_COLS  = 16;
  localparam int MAX_LABELS = 63;

  localparam int LABEL_W     = 6;
  localparam int LABEL_CAP   = (1 << LABEL_W) - 1;
  localparam int LABEL_LIMIT = (MAX_LABELS > LABEL_CAP) ? LABEL_CAP : MAX_LABELS;

  localparam int ROW_W  = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int COL_W  = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int POS_W  = 4;
  localparam int SIZE_W = 5;
  localparam int SUM_W  = 8;
  localparam int STAT_W = 2;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_REJECT  = 2'd1,
    ST_EXHAUST = 2'd2
  } res_code_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load;
    logic      clr_wr;
    logic      rd_issue;
    logic      wr_issue;
    logic      fill_start;
    logic      res_set;
    res_code_t res_code;
    logic      count_inc;
    logic      out_load;
  } rgp_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_read;
    logic in_grid;
    logic fits;
    logic exhausted;
    logic left_zero;
    logic overlap;
    logic clr_last;
    logic out_free;
  } rgp_sts_t;

endpackage

### rtl/rgp_datapath.sv
// ----------------------------------------------------------------------------
// rgp_datapath
// Row memory of cell labels with a masked write port, request registers,
// row and row-count counters, overlap detection, result and output registers.
// ----------------------------------------------------------------------------
module rgp_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_cmd,
  input  logic [rgp_pkg::POS_W-1:0]        in_corner_x,
  input  logic [rgp_pkg::POS_W-1:0]        in_corner_y,
  input  logic [rgp_pkg::SIZE_W-1:0]       in_rect_width,
  input  logic [rgp_pkg::SIZE_W-1:0]       in_rect_height,
  input  rgp_pkg::rgp_ctl_t                ctl,
  output rgp_pkg::rgp_sts_t                sts,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [rgp_pkg::STAT_W-1:0]       out_status,
  output logic [rgp_pkg::LABEL_W-1:0]      out_label,
  output logic [rgp_pkg::LABEL_W-1:0]      out_placed_count
);

  typedef logic [rgp_pkg::GRID_COLS-1:0][rgp_pkg::LABEL_W-1:0] row_t;

  row_t                            mem [rgp_pkg::GRID_ROWS];
  row_t                            rdata_r;

  logic                            cmd_r;
  logic [rgp_pkg::POS_W-1:0]       x_r;
  logic [rgp_pkg::POS_W-1:0]       y_r;
  logic [rgp_pkg::SIZE_W-1:0]      w_r;
  logic [rgp_pkg::SIZE_W-1:0]      h_r;
  logic [rgp_pkg::GRID_COLS-1:0]   mask_r;
  logic [rgp_pkg::GRID_COLS-1:0]   mask_nxt;
  logic [rgp_pkg::ROW_W-1:0]       row_r;
  logic [rgp_pkg::SIZE_W-1:0]      left_r;
  logic                            chk_pend_r;
  logic [rgp_pkg::LABEL_W-1:0]     total_r;
  logic [rgp_pkg::LABEL_W-1:0]     new_label;
  rgp_pkg::res_code_t              res_status_r;
  logic [rgp_pkg::LABEL_W-1:0]     res_label_r;
  logic [rgp_pkg::LABEL_W-1:0]     res_label_nxt;
  logic                            out_valid_r;
  rgp_pkg::res_code_t              out_status_r;
  logic [rgp_pkg::LABEL_W-1:0]     out_label_r;
  logic [rgp_pkg::LABEL_W-1:0]     out_count_r;
  logic                            mem_we;
  logic [rgp_pkg::GRID_COLS-1:0]   wmask;
  logic [rgp_pkg::LABEL_W-1:0]     wdata;
  logic [rgp_pkg::GRID_COLS-1:0]   hit;
  logic [rgp_pkg::SUM_W-1:0]       x_end;
  logic [rgp_pkg::SUM_W-1:0]       y_end;
  logic [rgp_pkg::SUM_W-1:0]       in_x_end;

  assign new_label = rgp_pkg::LABEL_W'(total_r + 1'b1);

  // Column mask of the rectangle, built from the incoming request.
  assign in_x_end = rgp_pkg::SUM_W'(in_corner_x) + rgp_pkg::SUM_W'(in_rect_width);
  always_comb begin
    for (int c = 0; c < rgp_pkg::GRID_COLS; c++) begin
      mask_nxt[c] = (rgp_pkg::SUM_W'(c) >= rgp_pkg::SUM_W'(in_corner_x)) &&
                    (rgp_pkg::SUM_W'(c) < in_x_end);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r  <= in_cmd;
      x_r    <= in_corner_x;
      y_r    <= in_corner_y;
      w_r    <= in_rect_width;
      h_r    <= in_rect_height;
      mask_r <= mask_nxt;
    end
  end

  // The row counter also sweeps the memory for the clearing pass after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else if (ctl.load) begin
      row_r <= rgp_pkg::ROW_W'(in_corner_y);
    end else if (ctl.fill_start) begin
      row_r <= rgp_pkg::ROW_W'(y_r);
    end else if (ctl.rd_issue || ctl.wr_issue || ctl.clr_wr) begin
      row_r <= rgp_pkg::ROW_W'(row_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      left_r <= in_rect_height;
    end else if (ctl.fill_start) begin
      left_r <= h_r;
    end else if (ctl.rd_issue || ctl.wr_issue) begin
      left_r <= rgp_pkg::SIZE_W'(left_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_pend_r <= 1'b0;
    end else begin
      chk_pend_r <= ctl.rd_issue;
    end
  end

  // Row memory: one masked write port and one registered read port.
  assign mem_we = ctl.wr_issue || ctl.clr_wr;
  assign wmask  = ctl.clr_wr ? '1 : mask_r;
  assign wdata  = ctl.clr_wr ? '0 : new_label;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      for (int c = 0; c < rgp_pkg::GRID_COLS; c++) begin
        if (wmask[c]) begin
          mem[row_r][c] <= wdata;
        end
      end
    end
    if (ctl.rd_issue) begin
      rdata_r <= mem[row_r];
    end
  end

  always_comb begin
    for (int c = 0; c < rgp_pkg::GRID_COLS; c++) begin
      hit[c] = mask_r[c] && (rdata_r[c] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (ctl.count_inc) begin
      total_r <= new_label;
    end
  end

  assign x_end = rgp_pkg::SUM_W'(x_r) + rgp_pkg::SUM_W'(w_r);
  assign y_end = rgp_pkg::SUM_W'(y_r) + rgp_pkg::SUM_W'(h_r);

  assign sts.is_read   = cmd_r;
  assign sts.in_grid   = (rgp_pkg::SUM_W'(x_r) < rgp_pkg::SUM_W'(rgp_pkg::GRID_COLS)) &&
                         (rgp_pkg::SUM_W'(y_r) < rgp_pkg::SUM_W'(rgp_pkg::GRID_ROWS));
  assign sts.fits      = (w_r != '0) && (h_r != '0) &&
                         (x_end <= rgp_pkg::SUM_W'(rgp_pkg::GRID_COLS)) &&
                         (y_end <= rgp_pkg::SUM_W'(rgp_pkg::GRID_ROWS));
  assign sts.exhausted = (total_r >= rgp_pkg::LABEL_W'(rgp_pkg::LABEL_LIMIT));
  assign sts.left_zero = (left_r == '0);
  assign sts.overlap   = chk_pend_r && (hit != '0);
  assign sts.clr_last  = (row_r == rgp_pkg::ROW_W'(rgp_pkg::GRID_ROWS - 1));
  assign sts.out_free  = !out_valid_r || !out_stall;

  // Result label: zero unless the request succeeded.
  always_comb begin
    if (ctl.res_code != rgp_pkg::ST_OK) begin
      res_label_nxt = '0;
    end else if (cmd_r) begin
      res_label_nxt = rdata_r[rgp_pkg::COL_W'(x_r)];
    end else begin
      res_label_nxt = new_label;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.res_set) begin
      res_status_r <= ctl.res_code;
      res_label_r  <= res_label_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_status_r <= res_status_r;
      out_label_r  <= res_label_r;
      out_count_r  <= total_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_label        = out_label_r;
  assign out_placed_count = out_count_r;

  a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (total_r != $past(total_r)) |->
      (total_r == rgp_pkg::LABEL_W'($past(total_r) + 1'b1)))
    else $error("placed count moved by other than one");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.rd_issue || ctl.wr_issue) |-> (int'(row_r) < rgp_pkg::GRID_ROWS))
    else $error("row memory accessed beyond the grid");

  a_fail_label_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != rgp_pkg::ST_OK) |-> (out_label_r == '0))
    else $error("failed request carries a nonzero label");

endmodule

### rtl/rgp_ctrl.sv
// ----------------------------------------------------------------------------
// rgp_ctrl
// Sequencer for the rectangle grid placer: clearing pass, request decode,
// row-by-row overlap check, row-by-row fill and result hand-off.
// ----------------------------------------------------------------------------
module rgp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output rgp_pkg::rgp_ctl_t  ctl,
  input  rgp_pkg::rgp_sts_t  sts
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CLEAR  = 7'b0000010,
    S_DECIDE = 7'b0000100,
    S_CHECK  = 7'b0001000,
    S_FILL   = 7'b0010000,
    S_RDONE  = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    ctl       = '0;
    in_stall  = 1'b1;
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        ctl.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.is_read) begin
          if (sts.in_grid) begin
            ctl.rd_issue = 1'b1;
            state_nxt    = S_RDONE;
          end else begin
            ctl.res_set  = 1'b1;
            ctl.res_code = rgp_pkg::ST_REJECT;
            state_nxt    = S_OUT;
          end
        end else if (sts.exhausted) begin
          ctl.res_set  = 1'b1;
          ctl.res_code = rgp_pkg::ST_EXHAUST;
          state_nxt    = S_OUT;
        end else if (!sts.fits) begin
          ctl.res_set  = 1'b1;
          ctl.res_code = rgp_pkg::ST_REJECT;
          state_nxt    = S_OUT;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        // Reads run one row ahead of the overlap test on the returned row.
        if (sts.overlap) begin
          ctl.res_set  = 1'b1;
          ctl.res_code = rgp_pkg::ST_REJECT;
          state_nxt    = S_OUT;
        end else if (!sts.left_zero) begin
          ctl.rd_issue = 1'b1;
        end else begin
          ctl.fill_start = 1'b1;
          state_nxt      = S_FILL;
        end
      end
      S_FILL: begin
        if (!sts.left_zero) begin
          ctl.wr_issue = 1'b1;
        end else begin
          ctl.res_set   = 1'b1;
          ctl.res_code  = rgp_pkg::ST_OK;
          ctl.count_inc = 1'b1;
          state_nxt     = S_OUT;
        end
      end
      S_RDONE: begin
        ctl.res_set  = 1'b1;
        ctl.res_code = rgp_pkg::ST_OK;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_no_fill_exhausted: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.wr_issue |-> !sts.exhausted)
    else $error("fill issued with labels exhausted");

  a_fill_after_check: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL) && (ctl.wr_issue || ctl.count_inc) |-> !sts.is_read)
    else $error("fill sequence running for a read request");

  a_fill_entry: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.fill_start |-> !sts.overlap && sts.fits)
    else $error("fill started on a rectangle that failed the check");

endmodule

### rtl/rect_grid_placer.sv
// ----------------------------------------------------------------------------
// rect_grid_placer
// Two-dimensional occupancy grid allocator: places labelled rectangles on a
// grid of cell labels after a row-by-row overlap check, and reads cells.
// ----------------------------------------------------------------------------
// A read is decoded and its row is read, unless it is refused as outside the grid. A place
// request is decoded, checked row by row for overlap and then filled row by row (one row per
// cycle), unless refused before the check or on an overlap. Each result then goes through the
// result and output registers. One request is worked on at a time; a new one is taken while
// the previous result waits in the output register.
// After reset a clearing pass zeroes the grid row by row before any request is taken.
module rect_grid_placer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_cmd,
  input  logic [rgp_pkg::POS_W-1:0]        in_corner_x,
  input  logic [rgp_pkg::POS_W-1:0]        in_corner_y,
  input  logic [rgp_pkg::SIZE_W-1:0]       in_rect_width,
  input  logic [rgp_pkg::SIZE_W-1:0]       in_rect_height,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [rgp_pkg::STAT_W-1:0]       out_status,
  output logic [rgp_pkg::LABEL_W-1:0]      out_label,
  output logic [rgp_pkg::LABEL_W-1:0]      out_placed_count
);

  rgp_pkg::rgp_ctl_t ctl;
  rgp_pkg::rgp_sts_t sts;

  rgp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .ctl      (ctl),
    .sts      (sts)
  );

  rgp_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_cmd           (in_cmd),
    .in_corner_x      (in_corner_x),
    .in_corner_y      (in_corner_y),
    .in_rect_width    (in_rect_width),
    .in_rect_height   (in_rect_height),
    .ctl              (ctl),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_label        (out_label),
    .out_placed_count (out_placed_count)
  );

endmodule
